@@ sv/sdpg_pkg.sv @@
// ----------------------------------------------------------------------------
// sdpg_pkg
// Shared types, constants and the microstep pin table for the step/direction
// pulse generator.
// ----------------------------------------------------------------------------
package sdpg_pkg;

   localparam int COUNT_BITS_DEF = 32;
   localparam int HALF_BITS      = 19;
   localparam int RATE_BITS      = 20;
   localparam int DIVIDEND_BITS  = 20;
   localparam int DIVISOR_BITS   = RATE_BITS + 1;
   localparam int MIN_HALF_BITS  = 10;
   localparam int MSTEP_BITS     = 5;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [DIVIDEND_BITS-1:0] US_PER_SEC = DIVIDEND_BITS'(1000000);

   // commands
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOTOR_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIRECTION    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MSTEP_DIV    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_HALF     = 2'd3;

   // ms1, ms2, ms3 per row: full, half, quarter, eighth, sixteenth
   localparam logic [2:0] MS_PINS [5] = '{3'b000, 3'b100, 3'b010, 3'b110, 3'b111};

   typedef struct packed {
      logic                 tick;
      logic                 stop;
      logic                 load;
      logic [HALF_BITS-1:0] half;
   } motion_ctrl_type;

   typedef struct packed {
      logic moving;
      logic step_level;
      logic done;
   } motion_stat_type;

   // returns {ms1, ms2, ms3}
   function automatic logic [2:0] ms_pins_of(input logic [MSTEP_BITS-1:0] div);
      logic [2:0] pins;
      case (div)
         5'd2:    pins = MS_PINS[1];
         5'd4:    pins = MS_PINS[2];
         5'd8:    pins = MS_PINS[3];
         5'd16:   pins = MS_PINS[4];
         default: pins = MS_PINS[0];
      endcase
      return pins;
   endfunction

endpackage

@@ sv/sdpg_divider.sv @@
// ----------------------------------------------------------------------------
// sdpg_divider
// Restoring divider, one quotient bit per cycle: microseconds per second
// divided by twice the step rate.
// ----------------------------------------------------------------------------
module sdpg_divider
   import sdpg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [RATE_BITS-1:0]     rate,
   output logic                     done,
   output logic [HALF_BITS-1:0]     quotient
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  dvs_ff, dvs_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     run_ff, run_in;
   logic                     done_ff, done_in;

   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS+1:0]  diff;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = US_PER_SEC;
         dvs_in = {rate, 1'b0};
         cnt_in = CNT_BITS'(DIVIDEND_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         // trial subtract, keep the result when it does not go negative
         if (!diff[DIVISOR_BITS+1]) begin
            rem_in = diff[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   // divisor is at least two, so the quotient fits the half period
   assign quotient = quo_ff[HALF_BITS-1:0];

endmodule

@@ sv/sdpg_motion.sv @@
// ----------------------------------------------------------------------------
// sdpg_motion
// Move state: half period timer, pulse phase, remaining steps and stop
// request. Reports the state as it will be after the current update.
// ----------------------------------------------------------------------------
module sdpg_motion
   import sdpg_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  motion_ctrl_type       ctrl,
   input  logic [COUNT_BITS-1:0] count,
   output motion_stat_type       stat,
   output logic                  moving
);

   logic                  moving_ff, moving_in;
   logic                  pulse_ff, pulse_in;
   logic                  stop_ff, stop_in;
   logic [HALF_BITS-1:0]  period_ff, period_in;
   logic [HALF_BITS-1:0]  timer_ff, timer_in;
   logic [COUNT_BITS-1:0] steps_ff, steps_in;
   logic                  done;

   logic [HALF_BITS-1:0]  timer_dec;
   logic [COUNT_BITS-1:0] steps_dec;

   assign timer_dec = timer_ff - 1'b1;
   assign steps_dec = steps_ff - 1'b1;

   always_comb begin
      moving_in = moving_ff;
      pulse_in  = pulse_ff;
      stop_in   = stop_ff;
      period_in = period_ff;
      timer_in  = timer_ff;
      steps_in  = steps_ff;
      done      = 1'b0;
      if (ctrl.load) begin
         period_in = ctrl.half;
         timer_in  = ctrl.half;
         steps_in  = count;
         pulse_in  = 1'b1;
         stop_in   = 1'b0;
         moving_in = 1'b1;
      end else if (ctrl.tick && moving_ff) begin
         timer_in = timer_dec;
         if (timer_dec == '0) begin
            if (pulse_ff) begin
               pulse_in = 1'b0;
               timer_in = period_ff;
            end else begin
               // end of the low half completes one step
               steps_in = steps_dec;
               if (steps_dec == '0 || stop_ff) begin
                  moving_in = 1'b0;
                  stop_in   = 1'b0;
                  done      = 1'b1;
               end else begin
                  pulse_in = 1'b1;
                  timer_in = period_ff;
               end
            end
         end
      end else if (ctrl.stop && moving_ff) begin
         stop_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff <= 1'b0;
         pulse_ff  <= 1'b0;
         stop_ff   <= 1'b0;
         period_ff <= '0;
         timer_ff  <= '0;
         steps_ff  <= '0;
      end else begin
         moving_ff <= moving_in;
         pulse_ff  <= pulse_in;
         stop_ff   <= stop_in;
         period_ff <= period_in;
         timer_ff  <= timer_in;
         steps_ff  <= steps_in;
      end
   end

   assign stat.moving     = moving_in;
   assign stat.step_level = moving_in & pulse_in;
   assign stat.done       = done;
   assign moving          = moving_ff;

endmodule

@@ sv/step_dir_pulse_generator.sv @@
// ----------------------------------------------------------------------------
// step_dir_pulse_generator
// Step/direction pulse generator: ticks, start and stop commands in, one
// pin status transfer out per command.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  cmd, step_count, step_rate, fault_n
//   rsp      out        rsp_valid/rsp_stall  pin levels, busy, done, fault
//   csr      in         csr_we               csr_index, csr_wdata
//
// Tick, stop and ignored starts load their result into the response
// registers as they are transferred. A start that begins a move loads
// the divider, waits while the bit-per-cycle restoring divider computes
// the half period, sees it finish and then loads the move once the
// response slot is free. req_stall is high from a start transfer until
// its result is loaded and while a result is held by rsp_stall.
// Synchronous reset clears the sequencing state and restores CSR defaults.
// ----------------------------------------------------------------------------
module step_dir_pulse_generator
   import sdpg_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
)(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_cmd,
   input  logic [31:0]               req_step_count,
   input  logic [RATE_BITS-1:0]      req_step_rate,
   input  logic                      req_fault_n,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_step_level,
   output logic                      rsp_dir_level,
   output logic                      rsp_enable_n,
   output logic                      rsp_ms1,
   output logic                      rsp_ms2,
   output logic                      rsp_ms3,
   output logic                      rsp_busy_res,
   output logic                      rsp_move_done,
   output logic                      rsp_fault_active,

   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic                     fault_ff, fault_in;

   logic                     enable_ff;
   logic                     dir_ff;
   logic [MSTEP_BITS-1:0]    mstep_ff;
   logic [MIN_HALF_BITS-1:0] min_half_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     step_ff, busy_ff, done_ff, fault_act_ff;
   logic                     dir_out_ff, enable_n_ff;
   logic [2:0]               ms_ff;

   logic                     accept;
   logic                     slot_free;
   logic                     out_load;
   logic                     out_fault;
   logic [COUNT_BITS-1:0]    count_masked;
   logic                     start_ok;
   logic                     div_start;
   logic                     div_done;
   logic [HALF_BITS-1:0]     quotient;
   logic [HALF_BITS-1:0]     floor_us;
   logic [HALF_BITS-1:0]     half;
   logic                     moving;
   motion_ctrl_type          mctrl;
   motion_stat_type          mstat;

   assign slot_free    = !(rsp_valid_ff && rsp_stall);
   assign req_stall    = (state_ff != ST_IDLE) || !slot_free;
   assign accept       = req_valid && !req_stall;
   assign count_masked = COUNT_BITS'(req_step_count);
   assign start_ok     = (req_cmd == CMD_START) && !moving && (count_masked != '0)
                         && (req_step_rate != '0);
   assign div_start    = accept && start_ok;

   // a zero floor is taken as one microsecond
   assign floor_us = (min_half_ff == '0) ? HALF_BITS'(1) : HALF_BITS'(min_half_ff);
   assign half     = (quotient < floor_us) ? floor_us : quotient;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      fault_in  = fault_ff;
      mctrl     = '0;
      mctrl.half = half;
      out_load  = 1'b0;
      out_fault = req_fault_n;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (start_ok) begin
                  count_in = count_masked;
                  fault_in = req_fault_n;
                  state_in = ST_DIV;
               end else begin
                  mctrl.tick = (req_cmd == CMD_TICK);
                  mctrl.stop = (req_cmd == CMD_STOP);
                  out_load   = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            out_fault = fault_ff;
            if (slot_free) begin
               mctrl.load = 1'b1;
               out_load   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   sdpg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rate     (req_step_rate),
      .done     (div_done),
      .quotient (quotient)
   );

   sdpg_motion #(
      .COUNT_BITS (COUNT_BITS)
   ) u_motion (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mctrl),
      .count  (count_ff),
      .stat   (mstat),
      .moving (moving)
   );

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      fault_ff <= fault_in;
      if (out_load) begin
         step_ff      <= mstat.step_level;
         busy_ff      <= mstat.moving;
         done_ff      <= mstat.done;
         fault_act_ff <= !out_fault;
         dir_out_ff   <= dir_ff;
         enable_n_ff  <= !enable_ff;
         ms_ff        <= ms_pins_of(mstep_ff);
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         dir_ff      <= 1'b0;
         mstep_ff    <= MSTEP_BITS'(1);
         min_half_ff <= MIN_HALF_BITS'(2);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MOTOR_ENABLE: enable_ff   <= csr_wdata[0];
            CSR_DIRECTION:    dir_ff      <= csr_wdata[0];
            CSR_MSTEP_DIV:    mstep_ff    <= csr_wdata[MSTEP_BITS-1:0];
            CSR_MIN_HALF:     min_half_ff <= csr_wdata[MIN_HALF_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_step_level   = step_ff;
   assign rsp_dir_level    = dir_out_ff;
   assign rsp_enable_n     = enable_n_ff;
   assign rsp_ms1          = ms_ff[2];
   assign rsp_ms2          = ms_ff[1];
   assign rsp_ms3          = ms_ff[0];
   assign rsp_busy_res     = busy_ff;
   assign rsp_move_done    = done_ff;
   assign rsp_fault_active = fault_act_ff;

endmodule
